@@ src/mcr_pkg.sv @@
// ----------------------------------------------------------------------------
// mcr_pkg: shared types and constants for the midpoint circle rasterizer
// Result kinds, the per-slot emission table and fixed field widths.
// ----------------------------------------------------------------------------
package mcr_pkg;

  // Result kinds carried on the master-side tuser.
  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_SPAN  = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  // Input selector carried on the slave-side tuser.
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // Fill pen sits in the high nibble of the color byte.
  localparam logic [7:0] FILL_MASK  = 8'hF0;
  localparam int         SPAN_COUNT = 4;

  // One iteration: four spans, eight points, plus a slot for the done result.
  localparam int NUM_POINTS = 8;
  localparam int NUM_SLOTS  = SPAN_COUNT + NUM_POINTS + 1;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] DONE_SLOT = SLOT_W'(NUM_SLOTS - 1);

  localparam int WALK_W = 12;   // walk_x (two's complement) and walk_y
  localparam int ERR_W  = 14;   // decision term
  localparam int OUT_W  = 14;   // output coordinates

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // How a slot builds its coordinates from the walk offsets.
  // Spans: column offset is the half width, col_neg unused.
  typedef struct packed {
    kind_t kind;
    logic  col_is_x;
    logic  col_neg;
    logic  row_is_x;
    logic  row_neg;
  } slot_t;

  function automatic slot_t slot_desc(input logic [SLOT_W-1:0] idx);
    slot_t s;
    s = '{kind: KIND_DONE, col_is_x: 1'b0, col_neg: 1'b0,
          row_is_x: 1'b0, row_neg: 1'b0};
    case (idx)
      SLOT_W'(0):  s = '{KIND_SPAN,  1'b0, 1'b0, 1'b1, 1'b0};
      SLOT_W'(1):  s = '{KIND_SPAN,  1'b1, 1'b0, 1'b0, 1'b0};
      SLOT_W'(2):  s = '{KIND_SPAN,  1'b1, 1'b0, 1'b0, 1'b1};
      SLOT_W'(3):  s = '{KIND_SPAN,  1'b0, 1'b0, 1'b1, 1'b1};
      SLOT_W'(4):  s = '{KIND_POINT, 1'b0, 1'b1, 1'b1, 1'b0};
      SLOT_W'(5):  s = '{KIND_POINT, 1'b0, 1'b0, 1'b1, 1'b0};
      SLOT_W'(6):  s = '{KIND_POINT, 1'b1, 1'b1, 1'b0, 1'b0};
      SLOT_W'(7):  s = '{KIND_POINT, 1'b1, 1'b0, 1'b0, 1'b0};
      SLOT_W'(8):  s = '{KIND_POINT, 1'b1, 1'b1, 1'b0, 1'b1};
      SLOT_W'(9):  s = '{KIND_POINT, 1'b1, 1'b0, 1'b0, 1'b1};
      SLOT_W'(10): s = '{KIND_POINT, 1'b0, 1'b1, 1'b1, 1'b1};
      SLOT_W'(11): s = '{KIND_POINT, 1'b0, 1'b0, 1'b1, 1'b1};
      default:     s = '{KIND_DONE,  1'b0, 1'b0, 1'b0, 1'b0};
    endcase
    return s;
  endfunction

endpackage

@@ src/midpoint_circle_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit: midpoint circle walk with optional fill
// Steps a midpoint circle one iteration per advance transaction and streams
// the resulting spans and octant points.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side (s_*): one transaction per command. s_tuser selects a start
//   (load center, radius, color byte, fill flag; no results) or an advance
//   (run one iteration of the walk).
//   Master side (m_*): one transaction per result. m_tuser gives the kind
//   (point, span, done), m_tlast marks the final result of an advance.
//   An advance emits up to four spans (fill on, empty spans dropped) and then
//   eight points; once the walk has ended it emits a single done result.
// Timing:
//   An advance lands in the job register when it is accepted, and its first
//   result loads from there into the output register once that register is
//   free. Results then leave one per cycle while m_tready stays high; an
//   advance gives 8 to 12 results (one for a done result), all through the
//   single result port. The next command is accepted in the cycle its
//   predecessor's last result loads into the output register.
// Reset and stall:
//   rst clears the walk (next advance gives done) and empties the result path.
//   When the receiver holds m_tready low, hold the output register, stop the
//   slot sequencer and drop s_tready until the pending results can move.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_unit
  import mcr_pkg::*;
#(
  parameter int COORD_WIDTH = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // center_x[11:0], center_y[23:12], radius[34:24], color[42:35],
  // fill_on[43], zero pad[47:44]
  input  logic [47:0] s_tdata,
  // action[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // x_first[13:0], x_final[27:14], row[41:28], pen[45:42], zero pad[47:46]
  output logic [47:0] m_tdata,
  // kind[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  // Input field unpacking
  logic [11:0] in_center_x;
  logic [11:0] in_center_y;
  logic [10:0] in_radius;
  logic [7:0]  in_color;
  logic        in_fill_on;

  assign in_center_x = s_tdata[11:0];
  assign in_center_y = s_tdata[23:12];
  assign in_radius   = s_tdata[34:24];
  assign in_color    = s_tdata[42:35];
  assign in_fill_on  = s_tdata[43];

  // Walk state
  logic                    walking;
  logic [COORD_WIDTH-1:0]  mid_x;
  logic [COORD_WIDTH-1:0]  mid_y;
  logic [WALK_W-1:0]       walk_x;   // two's complement
  logic [WALK_W-1:0]       walk_y;
  logic [ERR_W-1:0]        decision; // two's complement
  logic [7:0]              color_byte;
  logic                    fill_mode;

  // Job register: one iteration waiting to be streamed out
  slot_mask_t        job_mask;
  logic [OUT_W-1:0]  job_cx;
  logic [OUT_W-1:0]  job_cy;
  logic [OUT_W-1:0]  job_ox;
  logic [OUT_W-1:0]  job_oy;
  logic [3:0]        job_fill_pen;
  logic [3:0]        job_line_pen;

  // Output register
  kind_t             out_kind;
  logic [OUT_W-1:0]  out_x_first;
  logic [OUT_W-1:0]  out_x_final;
  logic [OUT_W-1:0]  out_row;
  logic [3:0]        out_pen;
  logic              out_last;

  // Handshake and sequencing
  logic              in_fire;
  logic              is_advance;
  logic              out_free;
  logic              job_active;
  logic              issue;
  logic              job_last;
  logic [SLOT_W-1:0] pick;
  slot_mask_t        pick_bit;
  slot_mask_t        job_rest;

  assign in_fire    = s_tvalid && s_tready;
  assign is_advance = (s_tuser == ACT_ADVANCE);
  assign out_free   = !m_tvalid || m_tready;
  assign job_active = |job_mask;
  assign issue      = job_active && out_free;

  // Lowest pending slot goes out first
  always_comb begin
    pick = DONE_SLOT;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (job_mask[i]) begin
        pick = SLOT_W'(i);
      end
    end
  end

  assign pick_bit = slot_mask_t'(1) << pick;
  assign job_rest = job_mask & ~pick_bit;
  assign job_last = (job_rest == '0);
  assign s_tready = !job_active || (issue && job_last);

  // One iteration of the decision update
  logic               walk_ended;
  logic signed [16:0] err0;
  logic signed [16:0] err1;
  logic signed [16:0] err2;
  logic [12:0]        y_step;
  logic signed [12:0] x_step;
  logic [12:0]        x_wide;
  slot_mask_t         new_mask;

  assign x_wide     = {walk_x[WALK_W-1], walk_x};
  assign walk_ended = !walking || ($signed(x_wide) < $signed({1'b0, walk_y}));

  always_comb begin
    err0   = {{3{decision[ERR_W-1]}}, decision};
    y_step = {1'b0, walk_y};
    err1   = err0;
    if (err0 <= 17'sd0) begin
      y_step = {1'b0, walk_y} + 13'd1;
      err1   = err0 + $signed({3'b000, y_step, 1'b1});
    end
    x_step = $signed(x_wide);
    err2   = err1;
    if (err1 > 17'sd0) begin
      x_step = $signed(x_wide) - 13'sd1;
      err2   = err1 - $signed({{3{x_step[12]}}, x_step, 1'b1});
    end
  end

  // Slots for the new job; spans only in fill mode, those of zero half width dropped
  always_comb begin
    new_mask = '0;
    if (walk_ended) begin
      new_mask[DONE_SLOT] = 1'b1;
    end else begin
      new_mask[SPAN_COUNT +: NUM_POINTS] = '1;
      if (fill_mode) begin
        new_mask[0] = (walk_y != '0);
        new_mask[1] = (walk_x != '0);
        new_mask[2] = (walk_x != '0);
        new_mask[3] = (walk_y != '0);
      end
    end
  end

  // State and job registers
  always_ff @(posedge clk) begin
    if (rst) begin
      walking    <= 1'b0;
      mid_x      <= '0;
      mid_y      <= '0;
      walk_x     <= '0;
      walk_y     <= '0;
      decision   <= '0;
      color_byte <= '0;
      fill_mode  <= 1'b0;
      job_mask   <= '0;
    end else begin
      // A new advance replaces the job whose last slot leaves this cycle
      if (in_fire && is_advance) begin
        job_mask <= new_mask;
      end else if (issue) begin
        job_mask <= job_rest;
      end
      if (in_fire && !is_advance) begin
        // Start: load the circle and rewind the walk
        mid_x      <= COORD_WIDTH'(in_center_x);
        mid_y      <= COORD_WIDTH'(in_center_y);
        walk_x     <= WALK_W'(in_radius);
        walk_y     <= '0;
        decision   <= '0;
        color_byte <= in_color;
        fill_mode  <= in_fill_on;
        walking    <= 1'b1;
      end else if (in_fire) begin
        if (walk_ended) begin
          walking <= 1'b0;
        end else begin
          walk_x   <= x_step[WALK_W-1:0];
          walk_y   <= y_step[WALK_W-1:0];
          decision <= err2[ERR_W-1:0];
        end
      end
    end
  end

  // Job payload: snapshot of the iteration before the update
  always_ff @(posedge clk) begin
    if (in_fire && is_advance) begin
      job_cx       <= OUT_W'(mid_x);
      job_cy       <= OUT_W'(mid_y);
      job_ox       <= {{(OUT_W - WALK_W){walk_x[WALK_W-1]}}, walk_x};
      job_oy       <= {{(OUT_W - WALK_W){1'b0}}, walk_y};
      job_fill_pen <= 4'((color_byte & FILL_MASK) >> SPAN_COUNT);
      job_line_pen <= color_byte[3:0];
    end
  end

  // Build the coordinates of the picked slot
  slot_t            sd;
  logic [OUT_W-1:0] col_off;
  logic [OUT_W-1:0] row_off;
  kind_t            res_kind;
  logic [OUT_W-1:0] res_x_first;
  logic [OUT_W-1:0] res_x_final;
  logic [OUT_W-1:0] res_row;
  logic [3:0]       res_pen;

  always_comb begin
    sd      = slot_desc(pick);
    col_off = sd.col_is_x ? job_ox : job_oy;
    row_off = sd.row_is_x ? job_ox : job_oy;
    res_kind    = sd.kind;
    res_row     = sd.row_neg ? (job_cy - row_off) : (job_cy + row_off);
    res_x_first = sd.col_neg ? (job_cx - col_off) : (job_cx + col_off);
    res_x_final = res_x_first;
    res_pen     = job_line_pen;
    case (sd.kind)
      KIND_SPAN: begin
        res_x_first = job_cx - col_off;
        res_x_final = job_cx + col_off - OUT_W'(1);
        res_pen     = job_fill_pen;
      end
      KIND_POINT: begin
        res_pen = job_line_pen;
      end
      default: begin
        res_x_first = '0;
        res_x_final = '0;
        res_row     = '0;
        res_pen     = '0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (issue) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_kind    <= res_kind;
      out_x_first <= res_x_first;
      out_x_final <= res_x_final;
      out_row     <= res_row;
      out_pen     <= res_pen;
      out_last    <= job_last;
    end
  end

  assign m_tdata = {2'b00, out_pen, out_row, out_x_final, out_x_first};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

@@ src/mcr_checker.sv @@
// ----------------------------------------------------------------------------
// mcr_checker: port-level checks for the midpoint circle rasterizer
// Watches the result stream for reset, stall and result-shape rules.
// ----------------------------------------------------------------------------
module mcr_checker
  import mcr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // Result path comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled result changed");

  // Done result stands alone with zero payload
  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_DONE) |-> m_tlast && (m_tdata == '0))
    else $error("malformed done result");

  // A point has one column and never uses the fourth kind code
  a_point_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_SPAN) && (m_tuser != KIND_DONE)
      |-> (m_tuser == KIND_POINT) && (m_tdata[13:0] == m_tdata[27:14]))
    else $error("malformed point result");

endmodule

bind midpoint_circle_rasterizer_unit mcr_checker u_mcr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
